[src/kee_pkg.sv]
// Shared types and constants of the keypad expression evaluator.
// No dependencies.
package kee_pkg;

    localparam int unsigned MAX_TERMS_DEF = 16;
    localparam int unsigned DATA_W        = 32;

    // Request types.
    localparam logic [1:0] REQ_DIGIT = 2'd0;
    localparam logic [1:0] REQ_OPER  = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_DIV0  = 2'd1;
    localparam logic [1:0] STS_TERMS = 2'd2;

    // Key characters.
    localparam logic [7:0] KEY_ZERO  = 8'd48;
    localparam logic [7:0] KEY_NINE  = 8'd57;
    localparam logic [7:0] KEY_PLUS  = 8'h2B;
    localparam logic [7:0] KEY_MINUS = 8'h2D;
    localparam logic [7:0] KEY_TIMES = 8'h2A;
    localparam logic [7:0] KEY_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

endpackage

[src/kee_if.sv]
// Valid/ready channels of the keypad expression evaluator.
// Depends on kee_pkg for the data width.
interface kee_key_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] key_char;
    modport source (output valid, req_type, key_char, input ready);
    modport sink   (input valid, req_type, key_char, output ready);
endinterface

interface kee_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [kee_pkg::DATA_W-1:0] result;
    logic [1:0]                      status;
    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

[src/keypad_expression_evaluator.sv]
// Keypad expression evaluator: an operator key is taken while idle; a digit key
// reads and rewrites its operand (S_DRD, S_DWR). Evaluate: S_RD, S_OP, S_NXT per operand,
// S_DIV for each division (one bit per cycle in the shared divider), then S_SUM, S_FIN.
// Throughput: one key at a time; the key port is ready only when idle.
// Reset (i_rst_n low, synchronous) clears control, the term count, the overflow
// flag and operand entry 0; entry 0 is also rewritten to zero after each evaluate.
module keypad_expression_evaluator #(
    parameter int unsigned MAX_TERMS = kee_pkg::MAX_TERMS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kee_key_if.sink      i_key,
    kee_res_if.source    o_res
);
    localparam int unsigned AW = $clog2(MAX_TERMS);
    localparam int unsigned DW = kee_pkg::DATA_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TERMS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DRD, S_DWR, S_RD, S_OP, S_DIV, S_NXT, S_SUM, S_FIN
    } t_state;

    // Operand and operator stores: one write, one registered read port each.
    logic [DW-1:0] r_opnd [MAX_TERMS];
    logic [1:0]    r_opr  [MAX_TERMS];
    logic [DW-1:0] r_rd;
    logic [1:0]    r_rdop;
    logic [AW-1:0] r_addr;

    t_state        r_state;
    logic [AW-1:0] r_tc;
    logic          r_ovf;
    logic [3:0]    r_dig;
    logic [AW-1:0] r_k;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_term;
    logic          r_pend_sub;
    logic [1:0]    r_prev_op;
    logic [DW-1:0] r_val;
    logic [1:0]    r_sts;
    // Shared restoring divider.
    logic [DW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_dvs;
    logic [4:0]    r_dcnt;
    logic          r_dneg;
    // Output register.
    logic          r_ovalid;
    logic [DW-1:0] r_ores;
    logic [1:0]    r_osts;

    logic          acc_key;
    logic          is_digit;
    logic          is_oper;
    kee_pkg::t_op  key_op;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic [DW-1:0] sum_acc;

    assign i_key.ready  = (r_state == S_IDLE);
    assign acc_key      = i_key.valid && i_key.ready;
    assign o_res.valid  = r_ovalid;
    assign o_res.result = r_ores;
    assign o_res.status = r_osts;

    // Decode the key.
    always_comb begin
        is_digit = (i_key.key_char >= kee_pkg::KEY_ZERO)
                && (i_key.key_char <= kee_pkg::KEY_NINE);
        is_oper  = 1'b1;
        key_op   = kee_pkg::OP_ADD;
        priority if (i_key.key_char == kee_pkg::KEY_PLUS)  key_op = kee_pkg::OP_ADD;
        else if     (i_key.key_char == kee_pkg::KEY_MINUS) key_op = kee_pkg::OP_SUB;
        else if     (i_key.key_char == kee_pkg::KEY_TIMES) key_op = kee_pkg::OP_MUL;
        else if     (i_key.key_char == kee_pkg::KEY_SLASH) key_op = kee_pkg::OP_DIV;
        else                                               is_oper = 1'b0;
    end

    // Operand store write port: digit update, new empty operand, or clear of entry 0.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_tc;
        wr_data = '0;
        priority if (!i_rst_n) begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end else if (r_state == S_DWR) begin
            wr_en   = 1'b1;
            wr_data = (r_rd << 3) + (r_rd << 1) + {{(DW-4){1'b0}}, r_dig};
        end else if (r_state == S_FIN) begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end else if (acc_key && i_key.req_type == kee_pkg::REQ_OPER && is_oper
                     && r_tc != LAST_IDX) begin
            wr_en   = 1'b1;
            wr_addr = r_tc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_opnd[wr_addr] <= wr_data;
        if (acc_key && i_key.req_type == kee_pkg::REQ_OPER && is_oper && r_tc != LAST_IDX)
            r_opr[r_tc] <= key_op;
        r_rd   <= r_opnd[r_addr];
        r_rdop <= r_opr[r_addr];
    end

    // Divider step and accumulator add/subtract.
    assign rem_sh  = {r_rem[DW-1:0], r_quo[DW-1]};
    assign diff    = rem_sh - {1'b0, r_dvs};
    assign sum_acc = r_pend_sub ? (r_acc - r_term) : (r_acc + r_term);

    // Sequencer: walk operands left to right, fold * and / into the running
    // term, and add or subtract the term into the accumulator at each + or - and at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tc     <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_addr   <= '0;
        end else begin
            if (r_ovalid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc_key) begin
                        unique case (i_key.req_type)
                            kee_pkg::REQ_DIGIT: begin
                                if (is_digit) begin
                                    r_dig   <= i_key.key_char[3:0];
                                    r_addr  <= r_tc;
                                    r_state <= S_DRD;
                                end
                            end
                            kee_pkg::REQ_OPER: begin
                                if (is_oper) begin
                                    if (r_tc == LAST_IDX) r_ovf <= 1'b1;
                                    else                  r_tc  <= r_tc + 1'b1;
                                end
                            end
                            kee_pkg::REQ_EVAL: begin
                                if (r_ovf) begin
                                    r_val   <= '0;
                                    r_sts   <= kee_pkg::STS_TERMS;
                                    r_state <= S_FIN;
                                end else begin
                                    r_addr     <= '0;
                                    r_k        <= '0;
                                    r_acc      <= '0;
                                    r_pend_sub <= 1'b0;
                                    r_state    <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DRD: r_state <= S_DWR;
                S_DWR: r_state <= S_IDLE;
                S_RD:  r_state <= S_OP;
                S_OP: begin
                    r_prev_op <= r_rdop;
                    r_state   <= S_NXT;
                    if (r_k == '0) begin
                        r_term <= r_rd;
                    end else begin
                        unique case (r_prev_op)
                            kee_pkg::OP_ADD, kee_pkg::OP_SUB: begin
                                r_acc      <= sum_acc;
                                r_pend_sub <= (r_prev_op == kee_pkg::OP_SUB);
                                r_term     <= r_rd;
                            end
                            kee_pkg::OP_MUL: r_term <= r_term * r_rd;
                            default: begin
                                if (r_rd == '0) begin
                                    r_val   <= '0;
                                    r_sts   <= kee_pkg::STS_DIV0;
                                    r_state <= S_FIN;
                                end else begin
                                    r_quo   <= r_term[DW-1] ? -r_term : r_term;
                                    r_dvs   <= r_rd[DW-1] ? -r_rd : r_rd;
                                    r_dneg  <= r_term[DW-1] ^ r_rd[DW-1];
                                    r_rem   <= '0;
                                    r_dcnt  <= 5'(DW - 1);
                                    r_state <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle.
                    if (diff[DW]) begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end else begin
                        r_rem <= diff;
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end
                    if (r_dcnt == '0) begin
                        r_term  <= r_dneg ? -{r_quo[DW-2:0], ~diff[DW]}
                                          :  {r_quo[DW-2:0], ~diff[DW]};
                        r_state <= S_NXT;
                    end else begin
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                end
                S_NXT: begin
                    if (r_k == r_tc) begin
                        r_state <= S_SUM;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_addr  <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_SUM: begin
                    r_val   <= sum_acc;
                    r_sts   <= kee_pkg::STS_OK;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Hold until the output register is free; entry 0 is cleared meanwhile.
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_ores   <= r_val;
                        r_osts   <= r_sts;
                        r_tc     <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_tc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tc <= LAST_IDX) else $error("term count beyond store");
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dvs != '0) else $error("divider started on zero");
    a_terms_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_osts == kee_pkg::STS_TERMS |-> r_ores == '0)
        else $error("too-many-terms result not zero");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> !i_key.ready) else $error("ready during divide");

endmodule
